@@ design/hgd_pkg.sv @@
// ----------------------------------------------------------------------------
// hgd_pkg
// Shared types and helpers for the wrapped hex grid distance block.
// ----------------------------------------------------------------------------
package hgd_pkg;

  localparam int unsigned RadiusW = 6;
  localparam int unsigned InW     = 9;
  localparam int unsigned OutW    = 10;
  localparam int unsigned DistW   = 11;
  localparam int unsigned WideW   = 12;
  localparam int unsigned NumCand = 7;   // B itself plus six mirror images
  localparam int unsigned NumOff  = 6;

  localparam logic [RadiusW-1:0] RadiusRst = 6'd24;
  localparam logic [OutW-1:0]    DistSat   = 10'h3FF;

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [8:0] z;
  } offset_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic signed [InW-1:0]  ax;
    logic signed [InW-1:0]  ay;
    logic signed [DistW-1:0] az;
    logic signed [OutW-1:0] dx;
    logic signed [OutW-1:0] dy;
    logic signed [DistW-1:0] dz;
    logic signed [InW-1:0]  bq;
    logic signed [InW-1:0]  br;
    logic                   outside;
  } front_item_t;

  // Result of the distance stage
  typedef struct packed {
    logic [NumCand-1:0][DistW-1:0] cand_d;
    logic [NumOff-1:0]             hit;
    logic signed [InW-1:0]         ax;
    logic signed [InW-1:0]         ay;
    logic signed [InW-1:0]         bq;
    logic signed [InW-1:0]         br;
    logic                          outside;
  } dist_item_t;

  // Offset of candidate k: zero for k == 0, mirror offset M(k-1) for k = 1..6
  function automatic offset_t hgd_offset(input logic [RadiusW-1:0] n,
                                         input logic [2:0] k);
    offset_t o;
    logic signed [8:0] a;
    logic signed [8:0] b;
    logic signed [8:0] c;
    a = $signed({3'b000, n});
    b = a + 9'sd1;
    c = (a <<< 1) + 9'sd1;
    unique case (k)
      3'd1: begin
        o.x = c;  o.y = -b; o.z = -a;
      end
      3'd2: begin
        o.x = a;  o.y = -c; o.z = b;
      end
      3'd3: begin
        o.x = -b; o.y = -a; o.z = c;
      end
      3'd4: begin
        o.x = -c; o.y = b;  o.z = a;
      end
      3'd5: begin
        o.x = -a; o.y = c;  o.z = -b;
      end
      3'd6: begin
        o.x = b;  o.y = a;  o.z = -c;
      end
      default: begin
        o.x = '0; o.y = '0; o.z = '0;
      end
    endcase
    return o;
  endfunction

  // Cube distance of a difference vector: largest absolute coordinate
  function automatic logic [DistW-1:0] hgd_cheb(input logic signed [WideW-1:0] x,
                                                input logic signed [WideW-1:0] y,
                                                input logic signed [WideW-1:0] z);
    logic [WideW-1:0] ux;
    logic [WideW-1:0] uy;
    logic [WideW-1:0] uz;
    logic [WideW-1:0] m;
    ux = x[WideW-1] ? WideW'(-x) : WideW'(x);
    uy = y[WideW-1] ? WideW'(-y) : WideW'(y);
    uz = z[WideW-1] ? WideW'(-z) : WideW'(z);
    m  = (ux > uy) ? ux : uy;
    m  = (m > uz) ? m : uz;
    return m[DistW-1:0];
  endfunction

endpackage

@@ design/wrapped_hex_grid_distance.sv @@
// ----------------------------------------------------------------------------
// wrapped_hex_grid_distance
// Takes one pair of axial points per cycle while in_stall is low and presents
// the wraparound hex distance on a grid of radius cfg_grid_radius, the mirror
// image of the second point nearest the first, and the first point folded
// back into the central hexagon. Sustained rate is one transaction per cycle
// when nothing stalls: the front register, the queue, the distance
// stage and the output register each pass one item per clock. A
// queue of QUEUE_DEPTH entries (at least 2) decouples the front from the
// back so either side can stall without bubbles. Write the radius only while
// no transaction is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module wrapped_hex_grid_distance #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hgd_pkg::RadiusW-1:0]       cfg_grid_radius,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hgd_pkg::InW-1:0]    in_ref_q,
  input  logic signed [hgd_pkg::InW-1:0]    in_ref_r,
  input  logic signed [hgd_pkg::InW-1:0]    in_other_q,
  input  logic signed [hgd_pkg::InW-1:0]    in_other_r,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hgd_pkg::OutW-1:0]          out_wrapped_distance,
  output logic signed [hgd_pkg::OutW-1:0]   out_near_q,
  output logic signed [hgd_pkg::OutW-1:0]   out_near_r,
  output logic signed [hgd_pkg::OutW-1:0]   out_home_q,
  output logic signed [hgd_pkg::OutW-1:0]   out_home_r,
  output logic                              out_was_outside
);

  logic [hgd_pkg::RadiusW-1:0] radius_r;
  logic [hgd_pkg::RadiusW-1:0] radius_nxt;

  logic                 push_valid;
  logic                 push_ready;
  hgd_pkg::front_item_t push_item;
  logic                 pop_valid;
  logic                 pop_ready;
  hgd_pkg::front_item_t pop_item;

  assign cfg_ready  = 1'b1;
  assign radius_nxt = (cfg_valid && cfg_ready) ? cfg_grid_radius : radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= hgd_pkg::RadiusRst;
    end else begin
      radius_r <= radius_nxt;
    end
  end

  hgd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_radius (radius_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_ref_q    (in_ref_q),
    .in_ref_r    (in_ref_r),
    .in_other_q  (in_other_q),
    .in_other_r  (in_other_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  hgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hgd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .grid_radius          (radius_r),
    .pop_valid            (pop_valid),
    .pop_ready            (pop_ready),
    .pop_item             (pop_item),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_wrapped_distance (out_wrapped_distance),
    .out_near_q           (out_near_q),
    .out_near_r           (out_near_r),
    .out_home_q           (out_home_q),
    .out_home_r           (out_home_r),
    .out_was_outside      (out_was_outside)
  );

endmodule

@@ design/hgd_front.sv @@
// ----------------------------------------------------------------------------
// hgd_front
// Accepts a point pair, forms cube coordinates and the B - A difference,
// and flags whether A lies outside the central hexagon.
// ----------------------------------------------------------------------------
module hgd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hgd_pkg::RadiusW-1:0]    grid_radius,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [hgd_pkg::InW-1:0] in_ref_q,
  input  logic signed [hgd_pkg::InW-1:0] in_ref_r,
  input  logic signed [hgd_pkg::InW-1:0] in_other_q,
  input  logic signed [hgd_pkg::InW-1:0] in_other_r,
  output logic                           push_valid,
  input  logic                           push_ready,
  output hgd_pkg::front_item_t           push_item
);

  logic                 f_v_r;
  logic                 f_v_nxt;
  hgd_pkg::front_item_t item_r;
  hgd_pkg::front_item_t item_nxt;
  logic                 f_adv;

  assign f_adv    = !f_v_r || push_ready;
  assign in_stall = !f_adv;
  assign f_v_nxt  = f_adv ? in_valid : 1'b1;

  always_comb begin
    logic signed [hgd_pkg::DistW-1:0] az;
    logic signed [hgd_pkg::OutW-1:0]  dx;
    logic signed [hgd_pkg::OutW-1:0]  dy;
    logic [hgd_pkg::DistW-1:0]        da;
    // -q-r reaches +512, one bit beyond the 10-bit signed range
    az = -hgd_pkg::DistW'(in_ref_q) - hgd_pkg::DistW'(in_ref_r);
    dx = hgd_pkg::OutW'(in_other_q) - hgd_pkg::OutW'(in_ref_q);
    dy = hgd_pkg::OutW'(in_other_r) - hgd_pkg::OutW'(in_ref_r);
    da = hgd_pkg::hgd_cheb(hgd_pkg::WideW'(in_ref_q), hgd_pkg::WideW'(in_ref_r),
                           hgd_pkg::WideW'(az));
    item_nxt.ax      = in_ref_q;
    item_nxt.ay      = in_ref_r;
    item_nxt.az      = az;
    item_nxt.dx      = dx;
    item_nxt.dy      = dy;
    item_nxt.dz      = -hgd_pkg::DistW'(dx) - hgd_pkg::DistW'(dy);
    item_nxt.bq      = in_other_q;
    item_nxt.br      = in_other_r;
    item_nxt.outside = da > {5'b00000, grid_radius};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && f_adv) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = f_v_r;
  assign push_item  = item_r;

endmodule

@@ design/hgd_queue.sv @@
// ----------------------------------------------------------------------------
// hgd_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module hgd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  hgd_pkg::front_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output hgd_pkg::front_item_t pop_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hgd_pkg::front_item_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/hgd_back.sv @@
// ----------------------------------------------------------------------------
// hgd_back
// Distance stage (seven candidate distances, six recentering tests) followed
// by selection into the output register.
// ----------------------------------------------------------------------------
module hgd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hgd_pkg::RadiusW-1:0]       grid_radius,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  hgd_pkg::front_item_t              pop_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hgd_pkg::OutW-1:0]          out_wrapped_distance,
  output logic signed [hgd_pkg::OutW-1:0]   out_near_q,
  output logic signed [hgd_pkg::OutW-1:0]   out_near_r,
  output logic signed [hgd_pkg::OutW-1:0]   out_home_q,
  output logic signed [hgd_pkg::OutW-1:0]   out_home_r,
  output logic                              out_was_outside
);

  logic                s1_v_r;
  logic                s1_v_nxt;
  hgd_pkg::dist_item_t s1_r;
  hgd_pkg::dist_item_t s1_nxt;
  logic                s1_adv;

  logic                            o_v_r;
  logic                            o_v_nxt;
  logic                            o_adv;
  logic [hgd_pkg::OutW-1:0]        dist_r;
  logic [hgd_pkg::OutW-1:0]        dist_nxt;
  logic signed [hgd_pkg::OutW-1:0] near_q_r;
  logic signed [hgd_pkg::OutW-1:0] near_q_nxt;
  logic signed [hgd_pkg::OutW-1:0] near_r_r;
  logic signed [hgd_pkg::OutW-1:0] near_r_nxt;
  logic signed [hgd_pkg::OutW-1:0] home_q_r;
  logic signed [hgd_pkg::OutW-1:0] home_q_nxt;
  logic signed [hgd_pkg::OutW-1:0] home_r_r;
  logic signed [hgd_pkg::OutW-1:0] home_r_nxt;
  logic                            moved_r;
  logic                            moved_nxt;

  assign o_adv     = !o_v_r || !out_stall;
  assign s1_adv    = !s1_v_r || o_adv;
  assign pop_ready = s1_adv;
  assign s1_v_nxt  = s1_adv ? pop_valid : 1'b1;
  assign o_v_nxt   = o_adv ? s1_v_r : 1'b1;

  // Distance stage
  always_comb begin
    hgd_pkg::offset_t                   off;
    logic signed [hgd_pkg::WideW-1:0]   cx;
    logic signed [hgd_pkg::WideW-1:0]   cy;
    logic signed [hgd_pkg::WideW-1:0]   cz;
    for (int k = 0; k < hgd_pkg::NumCand; k++) begin
      off = hgd_pkg::hgd_offset(grid_radius, 3'(k));
      cx  = hgd_pkg::WideW'(pop_item.dx) + hgd_pkg::WideW'(off.x);
      cy  = hgd_pkg::WideW'(pop_item.dy) + hgd_pkg::WideW'(off.y);
      cz  = hgd_pkg::WideW'(pop_item.dz) + hgd_pkg::WideW'(off.z);
      s1_nxt.cand_d[k] = hgd_pkg::hgd_cheb(cx, cy, cz);
    end
    for (int j = 0; j < hgd_pkg::NumOff; j++) begin
      off = hgd_pkg::hgd_offset(grid_radius, 3'(j + 1));
      cx  = hgd_pkg::WideW'(pop_item.ax) - hgd_pkg::WideW'(off.x);
      cy  = hgd_pkg::WideW'(pop_item.ay) - hgd_pkg::WideW'(off.y);
      cz  = hgd_pkg::WideW'(pop_item.az) - hgd_pkg::WideW'(off.z);
      s1_nxt.hit[j] = hgd_pkg::hgd_cheb(cx, cy, cz) <= {5'b00000, grid_radius};
    end
    s1_nxt.ax      = pop_item.ax;
    s1_nxt.ay      = pop_item.ay;
    s1_nxt.bq      = pop_item.bq;
    s1_nxt.br      = pop_item.br;
    s1_nxt.outside = pop_item.outside;
  end

  // Selection: strict less keeps the earlier candidate on a tie;
  // recentering takes the first offset in range
  always_comb begin
    logic [hgd_pkg::DistW-1:0] best_d;
    logic [2:0]                best_k;
    logic [2:0]                home_k;
    logic                      found;
    hgd_pkg::offset_t          noff;
    hgd_pkg::offset_t          hoff;
    best_d = s1_r.cand_d[0];
    best_k = '0;
    for (int k = 1; k < hgd_pkg::NumCand; k++) begin
      if (s1_r.cand_d[k] < best_d) begin
        best_d = s1_r.cand_d[k];
        best_k = 3'(k);
      end
    end
    found  = 1'b0;
    home_k = '0;
    for (int j = 0; j < hgd_pkg::NumOff; j++) begin
      if (!found && s1_r.hit[j]) begin
        found  = 1'b1;
        home_k = 3'(j + 1);
      end
    end
    moved_nxt = s1_r.outside && found;
    noff = hgd_pkg::hgd_offset(grid_radius, best_k);
    hoff = hgd_pkg::hgd_offset(grid_radius, moved_nxt ? home_k : 3'd0);
    dist_nxt   = best_d[hgd_pkg::DistW-1] ? hgd_pkg::DistSat : best_d[hgd_pkg::OutW-1:0];
    near_q_nxt = hgd_pkg::OutW'(s1_r.bq) + hgd_pkg::OutW'(noff.x);
    near_r_nxt = hgd_pkg::OutW'(s1_r.br) + hgd_pkg::OutW'(noff.y);
    home_q_nxt = hgd_pkg::OutW'(s1_r.ax) - hgd_pkg::OutW'(hoff.x);
    home_r_nxt = hgd_pkg::OutW'(s1_r.ay) - hgd_pkg::OutW'(hoff.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && s1_adv) begin
      s1_r <= s1_nxt;
    end
    if (s1_v_r && o_adv) begin
      dist_r   <= dist_nxt;
      near_q_r <= near_q_nxt;
      near_r_r <= near_r_nxt;
      home_q_r <= home_q_nxt;
      home_r_r <= home_r_nxt;
      moved_r  <= moved_nxt;
    end
  end

  assign out_valid            = o_v_r;
  assign out_wrapped_distance = dist_r;
  assign out_near_q           = near_q_r;
  assign out_near_r           = near_r_r;
  assign out_home_q           = home_q_r;
  assign out_home_r           = home_r_r;
  assign out_was_outside      = moved_r;

endmodule
